FILE: src/mlfr_pkg.sv
`timescale 1ns / 1ps
package mlfr_pkg;

	localparam int FRAME_LEN = 9;
	localparam int REPLY_LEN = 7;
	localparam int FIFO_DEPTH = 2;

	localparam logic [7:0] START_BYTE = 8'd67;
	localparam logic [7:0] BRAKE_CODE = 8'd80;
	localparam logic [7:0] REPLY_HEAD = 8'h59;
	localparam logic [3:0] BYTE3_POS = 4'd3;

	localparam logic [7:0] FLAG_L0 = 8'h10;
	localparam logic [7:0] FLAG_L1 = 8'h40;
	localparam logic [7:0] FLAG_L2 = 8'h02;
	localparam logic [7:0] FLAG_L3 = 8'h04;
	localparam logic [7:0] FLAG_L4 = 8'h08;

	localparam logic [2:0] ASSIST_RESET = 3'd0;
	localparam logic [7:0] WHEEL_RESET = 8'h1C;
	localparam logic [7:0] MAXSPD_RESET = 8'h1B;

	typedef enum logic [1:0] {
		REG_ASSIST = 2'd0,
		REG_WHEEL = 2'd1,
		REG_MAXSPD = 2'd2,
		REG_NONE = 2'd3
	} reg_idx_t;

	typedef enum logic [2:0] {
		RB_HEAD = 3'd0,
		RB_FLAG = 3'd1,
		RB_ZERO0 = 3'd2,
		RB_WHEEL = 3'd3,
		RB_ZERO1 = 3'd4,
		RB_MAXSPD = 3'd5,
		RB_SUM = 3'd6
	} reply_pos_t;

	typedef struct packed {
		logic       brake;
		logic [7:0] filtered;
	} job_t;

	typedef struct packed {
		logic [2:0] assist_level;
		logic [7:0] wheel_size;
		logic [7:0] max_speed;
	} cfg_t;

	typedef struct packed {
		logic full;
		logic empty;
	} qstat_t;

	function automatic logic [7:0] assist_flag(input logic [2:0] level);
		logic [7:0] f;
		unique case (level)
			3'd1: f = FLAG_L1;
			3'd2: f = FLAG_L2;
			3'd3: f = FLAG_L3;
			3'd4: f = FLAG_L4;
			default: f = FLAG_L0;
		endcase
		return f;
	endfunction

endpackage

FILE: src/motor_link_frame_responder.sv
`timescale 1ns / 1ps
// channel   dir  tdata            tuser                       tlast
// s_axis    in   [7:0] rx_byte    -                           -
// m_axis    out  [7:0] tx_byte    [0] brake, [8:1] filtered   last_byte
// apb       cfg  0x0 assist_level, 0x4 wheel_size, 0x8 max_speed
//
// Input: one byte per cycle; stalls only on a frame-closing byte while
// the two-entry reply queue is full.
// Output: seven reply bytes per frame, one per cycle while m_tready is high, from the output register.
// A frame of 9 bytes yields 7 output bytes; the reply queue lets a new frame arrive while a reply is still being sent.
// Reset is asynchronous, active low; config resets to 0, 0x1C, 0x1B.
module motor_link_frame_responder (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,  // [7:0] rx_byte
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,  // [7:0] tx_byte
	output logic [15:0] m_tuser,  // [0] brake_active, [8:1] current_filtered, rest 0
	output logic        m_tlast,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import mlfr_pkg::*;

	cfg_t     cfg_q;
	reg_idx_t widx;
	logic     wr_en;

	logic     push;
	logic     pop;
	job_t     push_job;
	job_t     head;
	qstat_t   q_stat;
	logic     brake;
	logic [7:0] filtered;

	assign pready = 1'b1;
	assign widx = reg_idx_t'(paddr[3:2]);
	assign wr_en = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.assist_level <= ASSIST_RESET;
			cfg_q.wheel_size <= WHEEL_RESET;
			cfg_q.max_speed <= MAXSPD_RESET;
		end else if (wr_en) begin
			unique case (widx)
				REG_ASSIST: cfg_q.assist_level <= pwdata[2:0];
				REG_WHEEL:  cfg_q.wheel_size <= pwdata[7:0];
				REG_MAXSPD: cfg_q.max_speed <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (widx)
			REG_ASSIST: prdata = {29'd0, cfg_q.assist_level};
			REG_WHEEL:  prdata = {24'd0, cfg_q.wheel_size};
			REG_MAXSPD: prdata = {24'd0, cfg_q.max_speed};
			default:    prdata = 32'd0;
		endcase
	end

	mlfr_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.rx_byte  (s_tdata),
		.q_stat   (q_stat),
		.push     (push),
		.push_job (push_job)
	);

	mlfr_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (push_job),
		.pop      (pop),
		.head     (head),
		.stat     (q_stat)
	);

	mlfr_back u_back (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg              (cfg_q),
		.head             (head),
		.q_stat           (q_stat),
		.pop              (pop),
		.out_valid        (m_tvalid),
		.out_ready        (m_tready),
		.tx_byte          (m_tdata),
		.last_byte        (m_tlast),
		.brake_active     (brake),
		.current_filtered (filtered)
	);

	assign m_tuser = {7'd0, filtered, brake};

`ifndef SYNTH
	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (!q_stat.full || pop))
		else $error("reply queue overflow");

	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !q_stat.empty)
		else $error("reply queue underflow");

	a_head_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tready && m_tlast) |=> (!m_tvalid || m_tdata == REPLY_HEAD))
		else $error("reply does not restart with head byte");
`endif

endmodule

FILE: src/mlfr_front.sv
`timescale 1ns / 1ps
module mlfr_front (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  logic [7:0]    rx_byte,
	input  mlfr_pkg::qstat_t q_stat,
	output logic          push,
	output mlfr_pkg::job_t push_job
);
	import mlfr_pkg::*;

	logic       in_frame_q;
	logic [3:0] count_q;
	logic [7:0] cur_byte_q;
	logic [9:0] acc_q;

	logic [3:0] cnt_next;
	logic       complete;
	logic       accept;
	logic [7:0] byte3;
	logic [9:0] acc_next;

	assign cnt_next = count_q + 4'd1;
	assign complete = in_frame_q && (cnt_next >= 4'(FRAME_LEN));
	assign in_ready = !(complete && q_stat.full);
	assign accept = in_valid && in_ready;
	assign byte3 = (count_q == BYTE3_POS) ? rx_byte : cur_byte_q;
	assign acc_next = 10'(acc_q - (acc_q >> 2) + {2'b00, byte3});

	assign push = accept && complete;
	assign push_job.brake = (byte3 == BRAKE_CODE);
	assign push_job.filtered = acc_next[9:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_frame_q <= 1'b0;
			count_q <= 4'd0;
			cur_byte_q <= 8'd0;
			acc_q <= 10'd0;
		end else if (accept) begin
			if (!in_frame_q) begin
				if (rx_byte == START_BYTE) begin
					in_frame_q <= 1'b1;
					count_q <= 4'd1;
				end else begin
					count_q <= 4'd0;
				end
			end else begin
				cur_byte_q <= byte3;
				if (complete) begin
					in_frame_q <= 1'b0;
					count_q <= 4'd0;
					acc_q <= acc_next;
				end else begin
					count_q <= cnt_next;
				end
			end
		end
	end

endmodule

FILE: src/mlfr_fifo.sv
`timescale 1ns / 1ps
module mlfr_fifo (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  mlfr_pkg::job_t   push_job,
	input  logic             pop,
	output mlfr_pkg::job_t   head,
	output mlfr_pkg::qstat_t stat
);
	import mlfr_pkg::*;

	localparam int PW = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
	localparam int CW = $clog2(FIFO_DEPTH + 1);

	job_t          mem_q [FIFO_DEPTH];
	logic [PW-1:0] wr_q;
	logic [PW-1:0] rd_q;
	logic [CW-1:0] cnt_q;

	assign head = mem_q[rd_q];
	assign stat.full = (cnt_q == CW'(FIFO_DEPTH));
	assign stat.empty = (cnt_q == '0);

	function automatic logic [PW-1:0] inc(input logic [PW-1:0] p);
		return (p == PW'(FIFO_DEPTH - 1)) ? '0 : PW'(p + 1'b1);
	endfunction

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= inc(wr_q);
			end
			if (pop) begin
				rd_q <= inc(rd_q);
			end
			if (push && !pop) begin
				cnt_q <= CW'(cnt_q + 1'b1);
			end else if (pop && !push) begin
				cnt_q <= CW'(cnt_q - 1'b1);
			end
		end
	end

endmodule

FILE: src/mlfr_back.sv
`timescale 1ns / 1ps
module mlfr_back (
	input  logic             clk,
	input  logic             arst_n,
	input  mlfr_pkg::cfg_t   cfg,
	input  mlfr_pkg::job_t   head,
	input  mlfr_pkg::qstat_t q_stat,
	output logic             pop,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [7:0]       tx_byte,
	output logic             last_byte,
	output logic             brake_active,
	output logic [7:0]       current_filtered
);
	import mlfr_pkg::*;

	reply_pos_t pos_q;
	logic       valid_q;
	logic [7:0] tx_q;
	logic       last_q;
	logic       brake_q;
	logic [7:0] filt_q;

	logic       load;
	logic [7:0] flag;
	logic [7:0] sum;
	logic [7:0] byte_sel;

	assign flag = assist_flag(cfg.assist_level);
	assign sum = 8'(REPLY_HEAD + flag + cfg.wheel_size + cfg.max_speed);

	always_comb begin
		unique case (pos_q)
			RB_HEAD:   byte_sel = REPLY_HEAD;
			RB_FLAG:   byte_sel = flag;
			RB_WHEEL:  byte_sel = cfg.wheel_size;
			RB_MAXSPD: byte_sel = cfg.max_speed;
			RB_SUM:    byte_sel = sum;
			default:   byte_sel = 8'd0;
		endcase
	end

	assign load = !valid_q || out_ready;
	assign pop = load && !q_stat.empty && (pos_q == RB_SUM);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= RB_HEAD;
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= !q_stat.empty;
			if (!q_stat.empty) begin
				pos_q <= (pos_q == RB_SUM) ? RB_HEAD : reply_pos_t'(pos_q + 3'd1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load && !q_stat.empty) begin
			tx_q <= byte_sel;
			last_q <= (pos_q == RB_SUM);
			brake_q <= head.brake;
			filt_q <= head.filtered;
		end
	end

	assign out_valid = valid_q;
	assign tx_byte = tx_q;
	assign last_byte = last_q;
	assign brake_active = brake_q;
	assign current_filtered = filt_q;

endmodule
